// ===== rtl/core/epgg_pkg.sv =====
// Shared widths, register codes, reset values and control structs of the grip estimator.
`default_nettype none

package epgg_pkg;

    localparam int TIME_W      = 16;
    localparam int THR_W       = 10;
    localparam int GRIP_W      = 10;
    localparam int SLOT_OUT_W  = 2;
    localparam int DIV_W       = 16;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 16;
    localparam int OUT_TDATA_W = ((GRIP_W + 1 + SLOT_OUT_W + 7) / 8) * 8;

    localparam int DEF_PULSE_SLOTS = 4;
    localparam int DEF_SAMPLE_BITS = 10;

    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COOLDOWN  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DECAY     = 2'd3;

    localparam logic [THR_W-1:0]  THR_RESET    = 10'd512;
    localparam logic [TIME_W-1:0] COOL_RESET   = 16'd100;
    localparam logic [TIME_W-1:0] WINDOW_RESET = 16'd500;
    localparam logic [TIME_W-1:0] DECAY_RESET  = 16'd1000;

    typedef struct packed {
        logic load_in;
        logic eval;
        logic calc;
        logic div_start;
        logic div_level;
        logic take_div;
        logic push_out;
    } epgg_cmd_t;

    typedef struct packed {
        logic dbl_hit;
        logic direct;
        logic div_done;
        logic q_zero;
        logic out_free;
    } epgg_sts_t;

endpackage

`default_nettype wire

// ===== rtl/core/epgg_div.sv =====
// Shared restoring divider, one quotient bit per cycle.
`default_nettype none

module epgg_div
    import epgg_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire logic [DIV_W-1:0] dividend,
    input  wire logic [DIV_W-1:0] divisor,
    output logic                  done,
    output logic [DIV_W-1:0]      quotient
);

    localparam int CNT_W = $clog2(DIV_W);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DIV_W - 1);

    logic             busy_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [DIV_W-1:0] rem_reg;
    logic [DIV_W-1:0] dvd_reg;
    logic [DIV_W-1:0] dvs_reg;
    logic [DIV_W:0]   trial;
    logic [DIV_W:0]   diff;
    logic             fits;
    logic [DIV_W-1:0] rem_next;

    assign trial    = {rem_reg, dvd_reg[DIV_W-1]};
    assign diff     = trial - {1'b0, dvs_reg};
    assign fits     = trial >= {1'b0, dvs_reg};
    assign rem_next = fits ? diff[DIV_W-1:0] : trial[DIV_W-1:0];

    assign done     = busy_reg && (cnt_reg == CNT_LAST);
    assign quotient = dvd_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + CNT_W'(1);
            if (cnt_reg == CNT_LAST)
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    // The dividend register fills with quotient bits from the bottom as it shifts out.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            dvd_reg <= dividend;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            dvd_reg <= {dvd_reg[DIV_W-2:0], fits};
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/epgg_ctrl.sv =====
// Sequencing state machine of the grip estimator.
`default_nettype none

module epgg_ctrl
    import epgg_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      in_valid,
    output logic           in_ready,
    input  wire epgg_sts_t sts,
    output epgg_cmd_t      cmd
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_EVAL  = 4'd1;
    localparam logic [3:0] S_RD2   = 4'd2;
    localparam logic [3:0] S_CALC  = 4'd3;
    localparam logic [3:0] S_DIVQ  = 4'd4;
    localparam logic [3:0] S_QCHK  = 4'd5;
    localparam logic [3:0] S_DIVL  = 4'd6;
    localparam logic [3:0] S_LTAKE = 4'd7;
    localparam logic [3:0] S_FIN   = 4'd8;

    logic [3:0] state_reg;
    logic [3:0] state_next;

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_in = 1'b1;
                    state_next  = S_EVAL;
                end
            end
            S_EVAL:
            begin
                cmd.eval   = 1'b1;
                state_next = S_RD2;
            end
            // The store reads are registered; this state lets the read registers take the updated slot before S_CALC.
            S_RD2:
            begin
                state_next = S_CALC;
            end
            S_CALC:
            begin
                cmd.calc = 1'b1;
                if (sts.dbl_hit || sts.direct)
                begin
                    state_next = S_FIN;
                end
                else
                begin
                    cmd.div_start = 1'b1;
                    state_next    = S_DIVQ;
                end
            end
            S_DIVQ:
            begin
                if (sts.div_done)
                begin
                    state_next = S_QCHK;
                end
            end
            S_QCHK:
            begin
                if (sts.q_zero)
                begin
                    state_next = S_FIN;
                end
                else
                begin
                    cmd.div_start = 1'b1;
                    cmd.div_level = 1'b1;
                    state_next    = S_DIVL;
                end
            end
            S_DIVL:
            begin
                if (sts.div_done)
                begin
                    state_next = S_LTAKE;
                end
            end
            S_LTAKE:
            begin
                cmd.take_div = 1'b1;
                state_next   = S_FIN;
            end
            S_FIN:
            begin
                if (sts.out_free)
                begin
                    cmd.push_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/epgg_dp.sv =====
// Datapath: configuration registers, pulse slot stores, level arithmetic and result register.
`default_nettype none

module epgg_dp
    import epgg_pkg::*;
#(
    parameter int PULSE_SLOTS = DEF_PULSE_SLOTS,
    parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   cfg_wr,
    input  wire logic [CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data,
    input  wire logic [SAMPLE_BITS-1:0] in_sample,
    input  wire logic [TIME_W-1:0]      in_time,
    input  wire epgg_cmd_t              cmd,
    output epgg_sts_t                   sts,
    output logic                        out_valid,
    input  wire logic                   out_ready,
    output logic [GRIP_W-1:0]           grip_level,
    output logic                        in_pulse,
    output logic [SLOT_OUT_W-1:0]       slot_index,
    output logic                        double_pulse
);

    localparam int SLOT_W = $clog2(PULSE_SLOTS);
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(PULSE_SLOTS - 1);

    // Configuration registers.
    logic [THR_W-1:0]  thr_reg;
    logic [TIME_W-1:0] cool_reg;
    logic [TIME_W-1:0] win_reg;
    logic [TIME_W-1:0] decay_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg   <= THR_RESET;
            cool_reg  <= COOL_RESET;
            win_reg   <= WINDOW_RESET;
            decay_reg <= DECAY_RESET;
        end
        else if (cfg_wr)
        begin
            unique case (cfg_index)
                CFG_THRESHOLD: thr_reg   <= cfg_data[THR_W-1:0];
                CFG_COOLDOWN:  cool_reg  <= cfg_data[TIME_W-1:0];
                CFG_WINDOW:    win_reg   <= cfg_data[TIME_W-1:0];
                CFG_DECAY:     decay_reg <= cfg_data[TIME_W-1:0];
            endcase
        end
    end

    // Input item.
    logic [SAMPLE_BITS-1:0] sample_reg;
    logic [TIME_W-1:0]      time_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            sample_reg <= in_sample;
            time_reg   <= in_time;
        end
    end

    // Pulse state.
    logic              meas_reg;
    logic              meas_next;
    logic [SLOT_W-1:0] cur_reg;
    logic [SLOT_W-1:0] cur_next;
    logic [SLOT_W-1:0] prev_slot;
    logic [SLOT_W-1:0] next_slot;

    assign prev_slot = (cur_reg == '0) ? LAST_SLOT : cur_reg - SLOT_W'(1);
    assign next_slot = (cur_reg == LAST_SLOT) ? '0 : cur_reg + SLOT_W'(1);

    // Slot stores; an entry never written reads as zero through its valid bit.
    logic [SAMPLE_BITS-1:0] peak_mem  [PULSE_SLOTS];
    logic [TIME_W-1:0]      start_mem [PULSE_SLOTS];
    logic [TIME_W-1:0]      end_mem   [PULSE_SLOTS];
    logic [PULSE_SLOTS-1:0] peak_vld_reg;
    logic [PULSE_SLOTS-1:0] start_vld_reg;
    logic [PULSE_SLOTS-1:0] end_vld_reg;

    logic [SAMPLE_BITS-1:0] peak_a_reg;
    logic [SAMPLE_BITS-1:0] peak_b_reg;
    logic [TIME_W-1:0]      start_a_reg;
    logic [TIME_W-1:0]      end_a_reg;
    logic [TIME_W-1:0]      end_b_reg;
    logic                   peak_a_vld_reg;
    logic                   peak_b_vld_reg;
    logic                   start_a_vld_reg;
    logic                   end_a_vld_reg;
    logic                   end_b_vld_reg;

    logic [SAMPLE_BITS-1:0] peak_a;
    logic [SAMPLE_BITS-1:0] peak_b;
    logic [TIME_W-1:0]      start_a;
    logic [TIME_W-1:0]      end_a;
    logic [TIME_W-1:0]      end_b;

    assign peak_a  = peak_a_vld_reg  ? peak_a_reg  : '0;
    assign peak_b  = peak_b_vld_reg  ? peak_b_reg  : '0;
    assign start_a = start_a_vld_reg ? start_a_reg : '0;
    assign end_a   = end_a_vld_reg   ? end_a_reg   : '0;
    assign end_b   = end_b_vld_reg   ? end_b_reg   : '0;

    // Port A follows the current slot, port B the one before it.
    always_ff @(posedge clk)
    begin
        peak_a_reg      <= peak_mem[cur_reg];
        peak_b_reg      <= peak_mem[prev_slot];
        start_a_reg     <= start_mem[cur_reg];
        end_a_reg       <= end_mem[cur_reg];
        end_b_reg       <= end_mem[prev_slot];
        peak_a_vld_reg  <= peak_vld_reg[cur_reg];
        peak_b_vld_reg  <= peak_vld_reg[prev_slot];
        start_a_vld_reg <= start_vld_reg[cur_reg];
        end_a_vld_reg   <= end_vld_reg[cur_reg];
        end_b_vld_reg   <= end_vld_reg[prev_slot];
    end

    // Pulse tracking decision.
    logic              above;
    logic [TIME_W-1:0] gap_end;
    logic [TIME_W-1:0] gap_start;
    logic              extend;
    logic              open_new;
    logic              close_now;
    logic              peak_we;
    logic [SLOT_W-1:0] peak_wa;
    logic              start_we;
    logic              end_we;

    assign above     = 16'(sample_reg) > 16'(thr_reg);
    assign gap_end   = time_reg - end_a;
    assign gap_start = time_reg - start_a;
    assign extend    = above && meas_reg;
    assign open_new  = above && !meas_reg && (gap_end > cool_reg);
    assign close_now = !above && meas_reg && (gap_start > cool_reg);

    assign peak_we  = cmd.eval && (open_new || (extend && (sample_reg > peak_a)));
    assign peak_wa  = open_new ? next_slot : cur_reg;
    assign start_we = cmd.eval && open_new;
    assign end_we   = cmd.eval && extend;

    always_comb
    begin
        meas_next = meas_reg;
        cur_next  = cur_reg;
        if (cmd.eval)
        begin
            if (open_new)
            begin
                meas_next = 1'b1;
                cur_next  = next_slot;
            end
            else if (close_now)
            begin
                meas_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            meas_reg      <= 1'b0;
            cur_reg       <= '0;
            peak_vld_reg  <= '0;
            start_vld_reg <= '0;
            end_vld_reg   <= '0;
        end
        else
        begin
            meas_reg <= meas_next;
            cur_reg  <= cur_next;
            if (peak_we)
            begin
                peak_vld_reg[peak_wa] <= 1'b1;
            end
            if (start_we)
            begin
                start_vld_reg[next_slot] <= 1'b1;
            end
            if (end_we)
            begin
                end_vld_reg[cur_reg] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (peak_we)
        begin
            peak_mem[peak_wa] <= sample_reg;
        end
        if (start_we)
        begin
            start_mem[next_slot] <= time_reg;
        end
        if (end_we)
        begin
            end_mem[cur_reg] <= time_reg;
        end
    end

    // Level arithmetic.
    logic [TIME_W-1:0]    dbl_gap;
    logic [SAMPLE_BITS:0] peak_sum;
    logic [DIV_W-1:0]     div_dvd;
    logic [DIV_W-1:0]     div_dvs;
    logic [DIV_W-1:0]     div_quo;
    logic                 div_done;

    assign dbl_gap  = start_a - end_b;
    assign peak_sum = {1'b0, peak_a} + {1'b0, peak_b};

    // First pass divides the time since the pulse end by the decay unit,
    // the second divides the peak by that quotient.
    assign div_dvd = cmd.div_level ? DIV_W'(peak_a) : gap_end;
    assign div_dvs = cmd.div_level ? div_quo : decay_reg;

    epgg_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (div_dvd),
        .divisor  (div_dvs),
        .done     (div_done),
        .quotient (div_quo)
    );

    assign sts.dbl_hit  = dbl_gap < win_reg;
    assign sts.direct   = meas_reg || (decay_reg == '0);
    assign sts.div_done = div_done;
    assign sts.q_zero   = (div_quo == '0);

    logic [SAMPLE_BITS-1:0] level_reg;
    logic                   dbl_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.calc)
        begin
            level_reg <= sts.dbl_hit ? peak_sum[SAMPLE_BITS:1] : peak_a;
            dbl_reg   <= sts.dbl_hit;
        end
        else if (cmd.take_div)
        begin
            level_reg <= SAMPLE_BITS'(div_quo);
        end
    end

    // Result register.
    logic out_valid_reg;

    assign sts.out_free = !out_valid_reg || out_ready;
    assign out_valid    = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.push_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.push_out)
        begin
            grip_level   <= GRIP_W'(level_reg);
            in_pulse     <= meas_reg;
            slot_index   <= SLOT_OUT_W'(cur_reg);
            double_pulse <= dbl_reg;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/emg_pulse_gesture_grip_top.sv =====
// Top level of the muscle pulse grip level estimator.
//
//  Channel    Direction  Transfer when             Carries
//  cfg        in         cfg_valid & cfg_ready     register index, write data
//  s_axis     in         s_axis_tvalid & tready    one sensor sample and timestamp
//  m_axis     out        m_axis_tvalid & tready    one grip result per sample
//
// A new sample is taken only in the idle state, after the last result was pushed. The level
// needs no division, one division when the decay quotient is zero, or two serial divisions
// on the shared divider otherwise.
// Reset clears the pulse state and the valid bits of all slot stores at once; no clearing pass is needed.
// A result waits in the output register while the next sample is taken in.
// Configuration writes are always accepted.
`default_nettype none

module emg_pulse_gesture_grip_top
    import epgg_pkg::*;
#(
    parameter int PULSE_SLOTS = DEF_PULSE_SLOTS,
    parameter int SAMPLE_BITS = DEF_SAMPLE_BITS,
    localparam int IN_TDATA_W = ((SAMPLE_BITS + TIME_W + 7) / 8) * 8
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    // Fields from bit 0: sample, time_ms, zero padding.
    input  wire logic [IN_TDATA_W-1:0] s_axis_tdata,
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    // Fields from bit 0: grip_level, in_pulse, slot_index, zero padding.
    output logic [OUT_TDATA_W-1:0]     m_axis_tdata,
    // Field: double_pulse.
    output logic                       m_axis_tuser
);

    epgg_cmd_t              cmd;
    epgg_sts_t              sts;
    logic [GRIP_W-1:0]      grip_level;
    logic                   in_pulse;
    logic [SLOT_OUT_W-1:0]  slot_index;

    assign cfg_ready = 1'b1;

    epgg_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    epgg_dp #(
        .PULSE_SLOTS (PULSE_SLOTS),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr       (cfg_valid),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_sample    (s_axis_tdata[SAMPLE_BITS-1:0]),
        .in_time      (s_axis_tdata[SAMPLE_BITS +: TIME_W]),
        .cmd          (cmd),
        .sts          (sts),
        .out_valid    (m_axis_tvalid),
        .out_ready    (m_axis_tready),
        .grip_level   (grip_level),
        .in_pulse     (in_pulse),
        .slot_index   (slot_index),
        .double_pulse (m_axis_tuser)
    );

    assign m_axis_tdata = OUT_TDATA_W'({slot_index, in_pulse, grip_level});

endmodule

`default_nettype wire
